// ===== rtl/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and constants for the idle shutdown and status LED controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ids_pkg;

   localparam int unsigned CSR_DATA_W  = 30;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned SUB_W       = 30;
   localparam int unsigned QTR_W       = 4;
   localparam int unsigned TIMER_W     = 20;
   localparam int unsigned RED_W       = 16;
   localparam int unsigned BLINK_W     = 4;
   localparam int unsigned PCT_W       = 7;

   localparam logic [QTR_W-1:0]   MAX_QUARTERS = 4'd15;
   localparam logic [BLINK_W:0]   BLINK_LIMIT  = 5'd4;
   localparam logic [BLINK_W:0]   BLINK_SAT    = 5'd15;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUARTER_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BATT_SHUTOFF  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLASH_TICKS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS     = 2'd3;

   localparam logic [SUB_W-1:0] QUARTER_TICKS_RST = 30'd150000;
   localparam logic [PCT_W-1:0] BATT_SHUTOFF_RST  = 7'd15;
   localparam logic [RED_W-1:0] FLASH_TICKS_RST   = 16'd50;
   localparam logic [RED_W-1:0] GAP_TICKS_RST     = 16'd2000;

   typedef enum logic [2:0] {
      PH_EVAL      = 3'd0,
      PH_FLASH     = 3'd1,
      PH_BLINK_ON  = 3'd2,
      PH_BLINK_OFF = 3'd3,
      PH_GAP       = 3'd4,
      PH_HALT      = 3'd5
   } phase_type;

   typedef struct packed {
      logic             user_activity;
      logic             usb_present;
      logic [PCT_W-1:0] battery_percent;
      logic             command_busy;
   } req_type;

   typedef struct packed {
      logic blue_led;
      logic red_led;
      logic power_off;
   } rsp_type;

   typedef struct packed {
      logic                   wr_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wr_data;
   } csr_type;

endpackage

`default_nettype wire

// ===== rtl/ids_ctrl.sv =====
// ----------------------------------------------------------------------------
// ids_ctrl
// Configuration registers, idle counters, red timeout and blink sequencer.
// Advances one tick per step and presents the tick's LED result.
// ----------------------------------------------------------------------------
`default_nettype none

module ids_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ids_pkg::csr_type csr,
   input  wire logic            step,
   input  wire ids_pkg::req_type req,
   output ids_pkg::rsp_type     rsp_next
);

   logic [ids_pkg::SUB_W-1:0]   quarter_ticks_ff;
   logic [ids_pkg::PCT_W-1:0]   batt_shutoff_ff;
   logic [ids_pkg::RED_W-1:0]   flash_ticks_ff;
   logic [ids_pkg::RED_W-1:0]   gap_ticks_ff;

   logic [ids_pkg::SUB_W-1:0]   sub_ff, sub_in;
   logic [ids_pkg::QTR_W-1:0]   quarters_ff, quarters_in;
   ids_pkg::phase_type          phase_ff, phase_in;
   logic [ids_pkg::BLINK_W-1:0] blinks_ff, blinks_in;
   logic [ids_pkg::TIMER_W-1:0] timer_ff, timer_in;
   logic                        blue_ff, blue_in;
   logic                        red_ff, red_in;
   logic [ids_pkg::RED_W-1:0]   red_timer_ff, red_timer_in;
   logic                        halted_ff, halted_in;

   logic [ids_pkg::TIMER_W-1:0] flash_len;
   logic [ids_pkg::TIMER_W-1:0] off_len;
   logic [ids_pkg::TIMER_W-1:0] gap_len;

   // 15x and 4x flash period
   assign flash_len = ({4'b0, flash_ticks_ff} << 4) - {4'b0, flash_ticks_ff};
   assign off_len   = {2'b0, flash_ticks_ff, 2'b0};
   assign gap_len   = {4'b0, gap_ticks_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ticks_ff <= ids_pkg::QUARTER_TICKS_RST;
         batt_shutoff_ff  <= ids_pkg::BATT_SHUTOFF_RST;
         flash_ticks_ff   <= ids_pkg::FLASH_TICKS_RST;
         gap_ticks_ff     <= ids_pkg::GAP_TICKS_RST;
      end else if (csr.wr_en) begin
         case (csr.index)
            ids_pkg::CSR_QUARTER_TICKS: quarter_ticks_ff <= csr.wr_data;
            ids_pkg::CSR_BATT_SHUTOFF:  batt_shutoff_ff  <= csr.wr_data[ids_pkg::PCT_W-1:0];
            ids_pkg::CSR_FLASH_TICKS:   flash_ticks_ff   <= csr.wr_data[ids_pkg::RED_W-1:0];
            ids_pkg::CSR_GAP_TICKS:     gap_ticks_ff     <= csr.wr_data[ids_pkg::RED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [ids_pkg::SUB_W-1:0]   sub_inc;
      logic [ids_pkg::RED_W-1:0]   red_inc;
      logic [ids_pkg::TIMER_W-1:0] timer_inc;
      logic [ids_pkg::BLINK_W:0]   blink_cnt;

      sub_in       = sub_ff;
      quarters_in  = quarters_ff;
      phase_in     = phase_ff;
      blinks_in    = blinks_ff;
      timer_in     = timer_ff;
      blue_in      = blue_ff;
      red_in       = red_ff;
      red_timer_in = red_timer_ff;
      halted_in    = halted_ff;
      sub_inc      = sub_ff + 1'b1;
      red_inc      = red_timer_ff + 1'b1;
      timer_inc    = timer_ff + 1'b1;
      blink_cnt    = '0;

      if (!halted_ff) begin
         // activity and idle counting, red timeout
         if (req.user_activity) begin
            sub_in       = '0;
            quarters_in  = '0;
            red_in       = 1'b1;
            red_timer_in = '0;
         end else begin
            if (sub_inc >= quarter_ticks_ff) begin
               sub_in = '0;
               if (quarters_ff < ids_pkg::MAX_QUARTERS) begin
                  quarters_in = quarters_ff + 1'b1;
               end
            end else begin
               sub_in = sub_inc;
            end
            if (red_ff) begin
               if (red_inc >= flash_ticks_ff) begin
                  red_in       = 1'b0;
                  red_timer_in = '0;
               end else begin
                  red_timer_in = red_inc;
               end
            end
         end

         case (phase_ff)
            ids_pkg::PH_FLASH: begin
               timer_in = timer_inc;
               if (timer_inc >= flash_len) begin
                  blue_in      = 1'b0;
                  red_in       = 1'b0;
                  red_timer_in = '0;
                  halted_in    = 1'b1;
                  phase_in     = ids_pkg::PH_HALT;
                  timer_in     = '0;
               end
            end
            ids_pkg::PH_BLINK_ON: begin
               timer_in = timer_inc;
               if (timer_inc >= {4'b0, flash_ticks_ff}) begin
                  blue_in  = req.command_busy;
                  phase_in = ids_pkg::PH_BLINK_OFF;
                  timer_in = '0;
               end
            end
            ids_pkg::PH_BLINK_OFF: begin
               timer_in = timer_inc;
               if (timer_inc >= off_len) begin
                  blinks_in = blinks_ff - 1'b1;
                  timer_in  = '0;
                  if (blinks_in != '0) begin
                     blue_in  = !req.command_busy;
                     phase_in = ids_pkg::PH_BLINK_ON;
                  end else begin
                     phase_in = ids_pkg::PH_GAP;
                  end
               end
            end
            ids_pkg::PH_GAP: begin
               timer_in = timer_inc;
               if (timer_inc >= gap_len) begin
                  phase_in = ids_pkg::PH_EVAL;
                  timer_in = '0;
               end
            end
            ids_pkg::PH_HALT: begin
            end
            default: begin
               // evaluate: blink count is the ceiling of elapsed quarters, saturated at 15, or 1 with USB present
               blink_cnt = {1'b0, quarters_in} + {{ids_pkg::BLINK_W{1'b0}}, (sub_in != '0)};
               if (blink_cnt > ids_pkg::BLINK_SAT) begin
                  blink_cnt = ids_pkg::BLINK_SAT;
               end
               if (req.usb_present) begin
                  blink_cnt = 5'd1;
               end
               timer_in = '0;
               if ((blink_cnt > ids_pkg::BLINK_LIMIT) &&
                   (req.battery_percent < batt_shutoff_ff)) begin
                  blue_in      = 1'b1;
                  red_in       = 1'b1;
                  red_timer_in = '0;
                  phase_in     = ids_pkg::PH_FLASH;
               end else begin
                  if (blink_cnt > ids_pkg::BLINK_LIMIT) begin
                     sub_in       = '0;
                     quarters_in  = '0;
                     red_in       = 1'b1;
                     red_timer_in = '0;
                  end
                  if (blink_cnt == '0) begin
                     phase_in = ids_pkg::PH_GAP;
                  end else begin
                     blinks_in = blink_cnt[ids_pkg::BLINK_W-1:0];
                     blue_in   = !req.command_busy;
                     phase_in  = ids_pkg::PH_BLINK_ON;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_next.blue_led  = blue_in;
      rsp_next.red_led   = red_in;
      rsp_next.power_off = halted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= '0;
         quarters_ff  <= '0;
         phase_ff     <= ids_pkg::PH_EVAL;
         blinks_ff    <= '0;
         timer_ff     <= '0;
         blue_ff      <= 1'b0;
         red_ff       <= 1'b0;
         red_timer_ff <= '0;
         halted_ff    <= 1'b0;
      end else if (step) begin
         sub_ff       <= sub_in;
         quarters_ff  <= quarters_in;
         phase_ff     <= phase_in;
         blinks_ff    <= blinks_in;
         timer_ff     <= timer_in;
         blue_ff      <= blue_in;
         red_ff       <= red_in;
         red_timer_ff <= red_timer_in;
         halted_ff    <= halted_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/idle_shutdown_status_led.sv =====
// ----------------------------------------------------------------------------
// idle_shutdown_status_led
// Tick-driven idle shutdown and status LED controller.
//
// Each req transaction is one millisecond tick carrying activity, USB
// presence, battery percent and command-busy. Each tick yields exactly one
// rsp transaction with the blue, red and power-off levels after that tick.
// rsp_valid rises when the accepted req transaction has passed the input
// register, then the state update and the result register; a stalled rsp
// can hold it in the input register between the two. One tick is accepted
// every cycle while rsp is not stalled; the state update is combinational.
// The csr port writes quarter_idle_ticks, battery_shutoff_percent,
// flash_ticks and gap_ticks by index; write only while no tick is in flight.
// Reset loads the register defaults, clears all counters and LEDs and puts
// the sequencer in its evaluate phase. A stalled rsp holds its payload; the
// input register keeps accepting until it is full, then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_shutdown_status_led (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire ids_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output ids_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_wr_en,
   input  wire logic [ids_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ids_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   logic             in_valid_ff;
   ids_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   ids_pkg::rsp_type out_data_ff;
   logic             advance;
   ids_pkg::csr_type csr;
   ids_pkg::rsp_type rsp_next;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      csr.wr_en   = csr_wr_en;
      csr.index   = csr_index;
      csr.wr_data = csr_wr_data;
   end

   ids_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .step     (advance),
      .req      (in_data_ff),
      .rsp_next (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
      end
   end

endmodule

`default_nettype wire
